>>> rtl/olrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olrb_pkg
// Shared types and constants of the overwrite log ring buffer.
// ----------------------------------------------------------------------------
package olrb_pkg;

  localparam int DEPTH    = 4096;
  localparam int MAX_READ = 64;
  localparam int QDEPTH   = 4;

  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int LIM_W   = $clog2(MAX_READ + 1);
  localparam int QIDX_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int BYTE_W  = 8;
  localparam int OP_W    = 2;
  localparam int INLIM_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_STORE,
    K_READ,
    K_CLEAR,
    K_REPORT
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [LIM_W-1:0]  limit;
  } cmd_t;

  typedef enum logic {
    ST_TAKE,
    ST_DRAIN
  } state_t;

endpackage
`default_nettype wire

>>> rtl/olrb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olrb_front
// Holds the enable register, classifies incoming commands and queues them.
// ----------------------------------------------------------------------------
module olrb_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [olrb_pkg::OP_W-1:0]    in_operation,
  input  wire  [olrb_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire  [olrb_pkg::INLIM_W-1:0] in_read_limit,
  input  wire                          cfg_we,
  input  wire                          cfg_wdata,
  output logic                         cmd_valid,
  output olrb_pkg::cmd_t               cmd,
  input  wire                          cmd_pop
);

  logic                         enable_r;
  olrb_pkg::cmd_t               q_r [olrb_pkg::QDEPTH];
  logic [olrb_pkg::QIDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [olrb_pkg::QIDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [olrb_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         push;
  olrb_pkg::cmd_t               new_cmd;

  assign busy      = (cnt_r == olrb_pkg::QCNT_W'(olrb_pkg::QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_idx_r];
  assign push      = start && !busy;

  always_comb begin
    new_cmd.data = in_data_byte;
    if (in_read_limit > olrb_pkg::INLIM_W'(olrb_pkg::MAX_READ)) begin
      new_cmd.limit = olrb_pkg::LIM_W'(olrb_pkg::MAX_READ);
    end else begin
      new_cmd.limit = olrb_pkg::LIM_W'(in_read_limit);
    end
    case (olrb_pkg::op_t'(in_operation))
      olrb_pkg::OP_WRITE: begin
        new_cmd.kind = enable_r ? olrb_pkg::K_STORE : olrb_pkg::K_REPORT;
      end
      olrb_pkg::OP_READ:  new_cmd.kind = olrb_pkg::K_READ;
      olrb_pkg::OP_CLEAR: new_cmd.kind = olrb_pkg::K_CLEAR;
      default:            new_cmd.kind = olrb_pkg::K_REPORT;
    endcase
  end

  always_comb begin
    wr_idx_nxt = push    ? wr_idx_r + olrb_pkg::QIDX_W'(1) : wr_idx_r;
    rd_idx_nxt = cmd_pop ? rd_idx_r + olrb_pkg::QIDX_W'(1) : rd_idx_r;
    cnt_nxt    = cnt_r;
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + olrb_pkg::QCNT_W'(1);
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - olrb_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_idx_r] <= new_cmd;
    end
  end

endmodule
`default_nettype wire

>>> rtl/olrb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olrb_back
// Executes queued commands against the byte store and registers the results.
// ----------------------------------------------------------------------------
module olrb_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cmd_valid,
  input  olrb_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  output logic                         out_strobe,
  output logic [olrb_pkg::BYTE_W-1:0]  out_read_byte,
  output logic                         out_byte_valid,
  output logic [olrb_pkg::CNT_W-1:0]   out_unread_count,
  output logic                         out_accepted,
  output logic                         out_last
);

  logic [olrb_pkg::BYTE_W-1:0] mem [olrb_pkg::DEPTH];
  logic [olrb_pkg::BYTE_W-1:0] rdata_r;

  olrb_pkg::state_t            st_r, st_nxt;
  logic [olrb_pkg::PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [olrb_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [olrb_pkg::CNT_W-1:0]  held_r, held_nxt;
  logic [olrb_pkg::LIM_W-1:0]  rem_r, rem_nxt;
  logic [olrb_pkg::LIM_W-1:0]  n_take;
  logic                        mem_we, mem_re;

  logic                        strobe_r, strobe_nxt;
  logic                        bvalid_r, bvalid_nxt;
  logic [olrb_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                        acc_r, acc_nxt;
  logic                        last_r, last_nxt;

  always_comb begin
    if (olrb_pkg::CNT_W'(cmd.limit) < held_r) begin
      n_take = cmd.limit;
    end else begin
      n_take = olrb_pkg::LIM_W'(held_r);
    end
  end

  always_comb begin
    st_nxt     = st_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    held_nxt   = held_r;
    rem_nxt    = rem_r;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    strobe_nxt = 1'b0;
    bvalid_nxt = 1'b0;
    count_nxt  = held_r;
    acc_nxt    = 1'b0;
    last_nxt   = 1'b0;
    case (st_r)
      olrb_pkg::ST_TAKE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            olrb_pkg::K_STORE: begin
              mem_we     = 1'b1;
              wr_ptr_nxt = wr_ptr_r + olrb_pkg::PTR_W'(1);
              if (held_r == olrb_pkg::CNT_W'(olrb_pkg::DEPTH)) begin
                rd_ptr_nxt = rd_ptr_r + olrb_pkg::PTR_W'(1);
              end else begin
                held_nxt = held_r + olrb_pkg::CNT_W'(1);
              end
              strobe_nxt = 1'b1;
              acc_nxt    = 1'b1;
              last_nxt   = 1'b1;
              count_nxt  = held_nxt;
            end
            olrb_pkg::K_READ: begin
              if (n_take == '0) begin
                strobe_nxt = 1'b1;
                last_nxt   = 1'b1;
              end else begin
                rem_nxt = n_take;
                st_nxt  = olrb_pkg::ST_DRAIN;
              end
            end
            olrb_pkg::K_CLEAR: begin
              wr_ptr_nxt = '0;
              rd_ptr_nxt = '0;
              held_nxt   = '0;
              strobe_nxt = 1'b1;
              last_nxt   = 1'b1;
              count_nxt  = '0;
            end
            default: begin
              strobe_nxt = 1'b1;
              last_nxt   = 1'b1;
            end
          endcase
        end
      end
      olrb_pkg::ST_DRAIN: begin
        mem_re     = 1'b1;
        rd_ptr_nxt = rd_ptr_r + olrb_pkg::PTR_W'(1);
        held_nxt   = held_r - olrb_pkg::CNT_W'(1);
        rem_nxt    = rem_r - olrb_pkg::LIM_W'(1);
        strobe_nxt = 1'b1;
        bvalid_nxt = 1'b1;
        count_nxt  = held_nxt;
        last_nxt   = (rem_r == olrb_pkg::LIM_W'(1));
        if (rem_r == olrb_pkg::LIM_W'(1)) begin
          st_nxt = olrb_pkg::ST_TAKE;
        end
      end
      default: st_nxt = olrb_pkg::ST_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= olrb_pkg::ST_TAKE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      held_r   <= '0;
      rem_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      held_r   <= held_nxt;
      rem_r    <= rem_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bvalid_r <= bvalid_nxt;
    count_r  <= count_nxt;
    acc_r    <= acc_nxt;
    last_r   <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= cmd.data;
    end
    if (mem_re) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  assign out_strobe       = strobe_r;
  assign out_byte_valid   = strobe_r && bvalid_r;
  assign out_read_byte    = (strobe_r && bvalid_r) ? rdata_r : '0;
  assign out_unread_count = count_r;
  assign out_accepted     = strobe_r && acc_r;
  assign out_last         = strobe_r && last_r;

endmodule
`default_nettype wire

>>> rtl/overwrite_log_ring_buffer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overwrite_log_ring_buffer
// Byte log ring buffer that drops its oldest byte when a write finds it full.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; it enters a
// four-entry command queue, and busy is high only while that queue is full.
// The execution side takes one queued command per cycle while it is not
// draining a read; a read drains n bytes, n being the smaller of its limit
// and the unread count, one byte per cycle from the single-port byte store.
// Each result sits on the out_ ports for one cycle with out_strobe high. A
// single result appears in the cycle right after its command leaves the
// queue, the first drained byte of a read once the drain state has loaded
// it into the byte register, and the remaining drained bytes of that read
// follow on consecutive cycles. Results cannot be held off, so the receiver
// must take every strobe. The byte store needs no initialisation after reset.
// ----------------------------------------------------------------------------
module overwrite_log_ring_buffer (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [olrb_pkg::OP_W-1:0]    in_operation,
  input  wire  [olrb_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire  [olrb_pkg::INLIM_W-1:0] in_read_limit,
  input  wire                          cfg_we,
  input  wire                          cfg_wdata,
  output logic                         out_strobe,
  output logic [olrb_pkg::BYTE_W-1:0]  out_read_byte,
  output logic                         out_byte_valid,
  output logic [olrb_pkg::CNT_W-1:0]   out_unread_count,
  output logic                         out_accepted,
  output logic                         out_last
);

  logic           cmd_valid;
  olrb_pkg::cmd_t cmd;
  logic           cmd_pop;

  olrb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_data_byte  (in_data_byte),
    .in_read_limit (in_read_limit),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  olrb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop),
    .out_strobe       (out_strobe),
    .out_read_byte    (out_read_byte),
    .out_byte_valid   (out_byte_valid),
    .out_unread_count (out_unread_count),
    .out_accepted     (out_accepted),
    .out_last         (out_last)
  );

  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe && out_byte_valid)
    else $error("drained bytes of one read are not contiguous");

  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=>
      out_unread_count == $past(out_unread_count) - olrb_pkg::CNT_W'(1))
    else $error("unread count does not fall by one per drained byte");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_accepted |-> out_last && !out_byte_valid && out_unread_count != '0)
    else $error("stored write result malformed");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_unread_count <= olrb_pkg::CNT_W'(olrb_pkg::DEPTH))
    else $error("unread count above depth");

endmodule
`default_nettype wire
